FILE: design/dtc_pkg.sv
// shared constants, types and helpers of the timestamp capture block
`default_nettype none
package dtc_pkg;

	localparam int FIFO_DEPTH     = 64;
	localparam int PTR_W          = $clog2(FIFO_DEPTH);
	localparam int STAMP_W        = 32;
	localparam int PRESCALE_W     = 16;
	localparam int CNT_W          = 7;
	localparam int MAX_RESULTS    = 64;
	localparam int OP_W           = 2;
	localparam int QUEUE_DEPTH    = 2;
	localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

	localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = PRESCALE_W'(83);

	typedef logic [OP_W-1:0]    opcode_t;
	typedef logic [PTR_W-1:0]   ptr_t;
	typedef logic [STAMP_W-1:0] stamp_t;

	localparam opcode_t OP_TICK    = 2'd0;
	localparam opcode_t OP_DRAIN_A = 2'd1;
	localparam opcode_t OP_DRAIN_B = 2'd2;

	localparam logic CHAN_A = 1'b0;
	localparam logic CHAN_B = 1'b1;

	// drain request handed from front to back
	typedef struct packed {
		logic             chan;
		logic [CNT_W-1:0] max_count;
	} cmd_t;

	// capture writes from front into the stores
	typedef struct packed {
		logic   we_a;
		logic   we_b;
		ptr_t   addr_a;
		ptr_t   addr_b;
		stamp_t data;
	} push_t;

	// read side status from back
	typedef struct packed {
		ptr_t rd_a;
		ptr_t rd_b;
		logic run;
	} back_stat_t;

	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} back_state_t;

	// ring pointer advance
	function automatic ptr_t ptr_next(input ptr_t p);
		ptr_t r;
		if (p == PTR_W'(FIFO_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: design/dtc_if.sv
// item channel interfaces of the timestamp capture block
`default_nettype none
interface dtc_in_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                opcode;
	logic                      edge_a;
	logic                      edge_b;
	logic [6:0]                max_count;

	modport source (output valid, opcode, edge_a, edge_b, max_count, input ready);
	modport sink   (input valid, opcode, edge_a, edge_b, max_count, output ready);
endinterface

interface dtc_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] stamp;
	logic        channel;
	logic        empty_res;
	logic        last;

	modport source (output valid, stamp, channel, empty_res, last, input ready);
	modport sink   (input valid, stamp, channel, empty_res, last, output ready);
endinterface
`default_nettype wire

FILE: design/dtc_front.sv
// front: accepts items, runs prescaler and timestamp, issues captures and drain requests
`default_nettype none
module dtc_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	dtc_in_if.sink                               in_ch,
	input  wire logic                            cfg_we,
	input  wire logic [dtc_pkg::PRESCALE_W-1:0]  cfg_wdata,
	input  wire dtc_pkg::back_stat_t             bstat,
	input  wire logic                            q_not_full,
	input  wire logic                            q_not_empty,
	output dtc_pkg::push_t                       push,
	output logic                                 q_push,
	output dtc_pkg::cmd_t                        q_cmd,
	output dtc_pkg::ptr_t                        wr_a,
	output dtc_pkg::ptr_t                        wr_b
);
	import dtc_pkg::*;

	logic [PRESCALE_W-1:0] prescale_q;
	logic [PRESCALE_W-1:0] pcount_q;
	stamp_t                ts_q;
	ptr_t                  wr_a_q;
	ptr_t                  wr_b_q;
	logic                  busy;
	logic                  accept;
	logic                  is_tick;
	logic                  is_drain;
	ptr_t                  nx_a;
	ptr_t                  nx_b;

	// ticks wait until every queued drain has moved its read pointer
	assign busy     = bstat.run | q_not_empty;
	assign is_tick  = (in_ch.opcode == OP_TICK);
	assign is_drain = (in_ch.opcode == OP_DRAIN_A) || (in_ch.opcode == OP_DRAIN_B);

	always_comb begin
		if (is_tick) begin
			in_ch.ready = !busy;
		end else if (is_drain) begin
			in_ch.ready = q_not_full;
		end else begin
			in_ch.ready = 1'b1;
		end
	end

	assign accept = in_ch.valid && in_ch.ready;

	// capture writes, dropped when the ring is full
	assign nx_a = ptr_next(wr_a_q);
	assign nx_b = ptr_next(wr_b_q);

	always_comb begin
		push.we_a   = accept && is_tick && in_ch.edge_a && (nx_a != bstat.rd_a);
		push.we_b   = accept && is_tick && in_ch.edge_b && (nx_b != bstat.rd_b);
		push.addr_a = wr_a_q;
		push.addr_b = wr_b_q;
		push.data   = ts_q;
	end

	// drain request into the queue
	assign q_push          = accept && is_drain;
	assign q_cmd.chan      = (in_ch.opcode == OP_DRAIN_B) ? CHAN_B : CHAN_A;
	assign q_cmd.max_count = in_ch.max_count;

	assign wr_a = wr_a_q;
	assign wr_b = wr_b_q;

	// prescale register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q <= PRESCALE_RESET;
		end else if (cfg_we) begin
			prescale_q <= cfg_wdata;
		end
	end

	// prescaler, timestamp and write pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcount_q <= '0;
			ts_q     <= '0;
			wr_a_q   <= '0;
			wr_b_q   <= '0;
		end else begin
			if (accept && is_tick) begin
				if (pcount_q >= prescale_q) begin
					pcount_q <= '0;
					ts_q     <= ts_q + STAMP_W'(1);
				end else begin
					pcount_q <= pcount_q + PRESCALE_W'(1);
				end
			end
			if (push.we_a) begin
				wr_a_q <= nx_a;
			end
			if (push.we_b) begin
				wr_b_q <= nx_b;
			end
		end
	end

endmodule
`default_nettype wire

FILE: design/dtc_cmd_queue.sv
// short queue of drain requests between front and back
`default_nettype none
module dtc_cmd_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire dtc_pkg::cmd_t  push_cmd,
	input  wire logic           pop,
	output dtc_pkg::cmd_t       head,
	output logic                not_empty,
	output logic                not_full
);
	import dtc_pkg::*;

	cmd_t              ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wp_q;
	logic [QPTR_W-1:0] rp_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign not_empty = (cnt_q != '0);
	assign not_full  = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign head      = ent_q[rp_q];
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wp_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rp_q <= (rp_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

FILE: design/dtc_back.sv
// back: holds both capture rings and streams drain results
`default_nettype none
module dtc_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire dtc_pkg::push_t  push,
	input  wire dtc_pkg::ptr_t   wr_a,
	input  wire dtc_pkg::ptr_t   wr_b,
	input  wire logic            cmd_valid,
	input  wire dtc_pkg::cmd_t   cmd,
	output logic                 cmd_pop,
	output dtc_pkg::back_stat_t  bstat,
	dtc_out_if.source            out_ch
);
	import dtc_pkg::*;

	stamp_t           mem_a_q [FIFO_DEPTH];
	stamp_t           mem_b_q [FIFO_DEPTH];

	back_state_t      state_q;
	back_state_t      state_d;
	ptr_t             rd_a_q;
	ptr_t             rd_b_q;
	logic             chan_q;
	logic [CNT_W-1:0] lim_q;
	logic [CNT_W-1:0] n_q;

	logic             v_s1;
	stamp_t           data_s1;
	logic             chan_s1;
	logic             empty_s1;
	logic             last_s1;

	logic             out_v_q;
	stamp_t           stamp_q;
	logic             chan_out_q;
	logic             empty_q;
	logic             last_q;

	logic             adv2;
	logic             s1_free;
	logic             load_empty;
	logic             start_run;
	logic             issue;
	logic             issue_last;
	logic [CNT_W-1:0] cmd_lim;
	ptr_t             cmd_rd;
	ptr_t             cmd_wr;
	ptr_t             cur_rd;
	ptr_t             cur_wr;
	ptr_t             nx_rd;

	// pipeline flow
	assign adv2    = !out_v_q || out_ch.ready;
	assign s1_free = !v_s1 || adv2;

	// request decode
	assign cmd_lim = (cmd.max_count > CNT_W'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : cmd.max_count;
	assign cmd_rd  = (cmd.chan == CHAN_B) ? rd_b_q : rd_a_q;
	assign cmd_wr  = (cmd.chan == CHAN_B) ? wr_b : wr_a;

	// running drain
	assign cur_rd     = (chan_q == CHAN_B) ? rd_b_q : rd_a_q;
	assign cur_wr     = (chan_q == CHAN_B) ? wr_b : wr_a;
	assign nx_rd      = ptr_next(cur_rd);
	assign issue_last = (nx_rd == cur_wr) || ((n_q + CNT_W'(1)) == lim_q);

	// drain sequencer
	always_comb begin
		state_d    = state_q;
		cmd_pop    = 1'b0;
		load_empty = 1'b0;
		start_run  = 1'b0;
		issue      = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid && s1_free) begin
					cmd_pop = 1'b1;
					if ((cmd_lim == '0) || (cmd_rd == cmd_wr)) begin
						load_empty = 1'b1;
					end else begin
						start_run = 1'b1;
						state_d   = BK_RUN;
					end
				end
			end
			BK_RUN: begin
				if (s1_free) begin
					issue = 1'b1;
					if (issue_last) begin
						state_d = BK_IDLE;
					end
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ring writes
	always_ff @(posedge clk) begin
		if (push.we_a) begin
			mem_a_q[push.addr_a] <= push.data;
		end
		if (push.we_b) begin
			mem_b_q[push.addr_b] <= push.data;
		end
	end

	// read pointers and drain counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_a_q <= '0;
			rd_b_q <= '0;
			chan_q <= CHAN_A;
			lim_q  <= '0;
			n_q    <= '0;
		end else begin
			if (start_run) begin
				chan_q <= cmd.chan;
				lim_q  <= cmd_lim;
				n_q    <= '0;
			end else if (issue) begin
				n_q <= n_q + CNT_W'(1);
				if (chan_q == CHAN_B) begin
					rd_b_q <= nx_rd;
				end else begin
					rd_a_q <= nx_rd;
				end
			end
		end
	end

	// read data stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (issue || load_empty) begin
			v_s1 <= 1'b1;
		end else if (adv2) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			data_s1  <= (chan_q == CHAN_B) ? mem_b_q[rd_b_q] : mem_a_q[rd_a_q];
			chan_s1  <= chan_q;
			empty_s1 <= 1'b0;
			last_s1  <= issue_last;
		end else if (load_empty) begin
			data_s1  <= '0;
			chan_s1  <= cmd.chan;
			empty_s1 <= 1'b1;
			last_s1  <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv2) begin
			out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			stamp_q    <= empty_s1 ? '0 : data_s1;
			chan_out_q <= chan_s1;
			empty_q    <= empty_s1;
			last_q     <= last_s1;
		end
	end

	assign out_ch.valid     = out_v_q;
	assign out_ch.stamp     = stamp_q;
	assign out_ch.channel   = chan_out_q;
	assign out_ch.empty_res = empty_q;
	assign out_ch.last      = last_q;

	assign bstat.rd_a = rd_a_q;
	assign bstat.rd_b = rd_b_q;
	assign bstat.run  = (state_q == BK_RUN);

endmodule
`default_nettype wire

FILE: design/dual_channel_timestamp_capture_fifo_core.sv
// top level of the two-channel timestamp capture block
//
//  port      | role          | carries
//  ----------+---------------+----------------------------------------------
//  in_ch     | item sink     | opcode, edge_a, edge_b, max_count
//  out_ch    | item source   | stamp, channel, empty_res, last
//  cfg_we    | register port | cfg_wdata written to prescale
//
// a tick item is taken every cycle while no drain is queued or running.
// a drain of n entries returns one item per cycle while the output is not
// stalled; after the drain is accepted, its first item passes the queue,
// the sequencer start, the ring read register and the output register; an
// empty drain item skips the sequencer start. up to two drain requests wait
// in the queue. ticks hold off until all queued drains have moved the read
// pointer. reset clears pointers, timestamp and prescaler; ring contents
// are not cleared. output stalls back up into the ring reads.
`default_nettype none
module dual_channel_timestamp_capture_fifo_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	dtc_in_if.sink                               in_ch,
	dtc_out_if.source                            out_ch,
	input  wire logic                            cfg_we,
	input  wire logic [dtc_pkg::PRESCALE_W-1:0]  cfg_wdata
);
	import dtc_pkg::*;

	push_t      push;
	back_stat_t bstat;
	cmd_t       q_cmd;
	cmd_t       q_head;
	logic       q_push;
	logic       q_pop;
	logic       q_not_full;
	logic       q_not_empty;
	ptr_t       wr_a;
	ptr_t       wr_b;

	dtc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.bstat       (bstat),
		.q_not_full  (q_not_full),
		.q_not_empty (q_not_empty),
		.push        (push),
		.q_push      (q_push),
		.q_cmd       (q_cmd),
		.wr_a        (wr_a),
		.wr_b        (wr_b)
	);

	dtc_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_cmd),
		.pop       (q_pop),
		.head      (q_head),
		.not_empty (q_not_empty),
		.not_full  (q_not_full)
	);

	dtc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_a      (wr_a),
		.wr_b      (wr_b),
		.cmd_valid (q_not_empty),
		.cmd       (q_head),
		.cmd_pop   (q_pop),
		.bstat     (bstat),
		.out_ch    (out_ch)
	);

endmodule
`default_nettype wire

FILE: tb/tb.sv
// self-checking testbench of the two-channel timestamp capture block

// predicted state of the block and the result items still owed by it
class capture_scoreboard;
	typedef struct {
		dtc_pkg::stamp_t stamp;
		logic            channel;
		logic            empty_res;
		logic            last;
	} capture_result_t;

	logic [dtc_pkg::PRESCALE_W-1:0] prescale;
	logic [dtc_pkg::PRESCALE_W-1:0] tick_count;
	dtc_pkg::stamp_t                now_stamp;
	dtc_pkg::stamp_t                ring [2][dtc_pkg::FIFO_DEPTH];
	dtc_pkg::ptr_t                  wr_slot [2];
	dtc_pkg::ptr_t                  rd_slot [2];
	capture_result_t                owed_q [$];
	int                             errors;

	function new();
		prescale   = dtc_pkg::PRESCALE_RESET;
		tick_count = '0;
		now_stamp  = '0;
		wr_slot    = '{'0, '0};
		rd_slot    = '{'0, '0};
		errors     = 0;
	endfunction

	function dtc_pkg::ptr_t step_slot(dtc_pkg::ptr_t p);
		return dtc_pkg::ptr_t'((int'(p) + 1) % dtc_pkg::FIFO_DEPTH);
	endfunction

	function void set_prescale(logic [dtc_pkg::PRESCALE_W-1:0] value);
		prescale = value;
	endfunction

	function int owed();
		return owed_q.size();
	endfunction

	// advance the capture state by one accepted item
	function void note_input(dtc_pkg::opcode_t op, logic ea, logic eb,
			logic [dtc_pkg::CNT_W-1:0] max_count);
		logic [1:0]      edges;
		int              c;
		int              i;
		int              held;
		int              take;
		capture_result_t r;
		edges = {eb, ea};
		if (op == dtc_pkg::OP_TICK) begin
			// capture the stamp before this tick's advance, channel a first
			for (c = 0; c < 2; c++) begin
				if (edges[c] && step_slot(wr_slot[c]) != rd_slot[c]) begin
					ring[c][wr_slot[c]] = now_stamp;
					wr_slot[c] = step_slot(wr_slot[c]);
				end
			end
			// prescaler, count wraps once it reaches or passes the setting
			if (tick_count >= prescale) begin
				tick_count = '0;
				now_stamp  = now_stamp + 1'b1;
			end else begin
				tick_count = tick_count + 1'b1;
			end
		end else if (op == dtc_pkg::OP_DRAIN_A || op == dtc_pkg::OP_DRAIN_B) begin
			c    = (op == dtc_pkg::OP_DRAIN_B) ? 1 : 0;
			held = (int'(wr_slot[c]) - int'(rd_slot[c]) + dtc_pkg::FIFO_DEPTH)
				% dtc_pkg::FIFO_DEPTH;
			take = (int'(max_count) > dtc_pkg::MAX_RESULTS) ? dtc_pkg::MAX_RESULTS
				: int'(max_count);
			if (held < take) begin
				take = held;
			end
			r.channel = (c == 1) ? dtc_pkg::CHAN_B : dtc_pkg::CHAN_A;
			// nothing to return gives a single empty marker
			if (take == 0) begin
				r.stamp     = '0;
				r.empty_res = 1'b1;
				r.last      = 1'b1;
				owed_q.push_back(r);
			end
			for (i = 0; i < take; i++) begin
				r.stamp     = ring[c][rd_slot[c]];
				r.empty_res = 1'b0;
				r.last      = (i == take - 1);
				owed_q.push_back(r);
				rd_slot[c] = step_slot(rd_slot[c]);
			end
		end
	endfunction

	// compare one result item with the oldest one owed
	function void check_result(dtc_pkg::stamp_t stamp, logic channel, logic empty_res,
			logic last);
		capture_result_t want;
		if (owed_q.size() == 0) begin
			$error("result item with none owed: stamp %08h channel %0d", stamp, channel);
			errors++;
			return;
		end
		want = owed_q.pop_front();
		if (stamp !== want.stamp) begin
			$error("stamp: expected %08h, actual %08h", want.stamp, stamp);
			errors++;
		end
		if (channel !== want.channel) begin
			$error("channel: expected %0d, actual %0d", want.channel, channel);
			errors++;
		end
		if (empty_res !== want.empty_res) begin
			$error("empty_res: expected %0d, actual %0d", want.empty_res, empty_res);
			errors++;
		end
		if (last !== want.last) begin
			$error("last: expected %0d, actual %0d", want.last, last);
			errors++;
		end
	endfunction
endclass

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dtc_pkg::*;

	localparam opcode_t OP_IGNORED       = 2'd3;
	localparam int      SETTLE_CYCLES    = 12;
	localparam int      RANDOM_PER_PHASE = 45;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [PRESCALE_W-1:0] cfg_wdata;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_left      = 0;

	capture_scoreboard sb = new();

	dtc_in_if  in_ch ();
	dtc_out_if out_ch ();

	dual_channel_timestamp_capture_fifo_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// 100 MHz clock
	always begin
		#5ns clk = 1'b1;
		#5ns clk = 1'b0;
	end

	// offer one item, with random idle cycles ahead of it, until accepted
	task automatic send_item(input opcode_t op, input logic ea, input logic eb,
			input logic [CNT_W-1:0] max_count);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.opcode    <= op;
		in_ch.edge_a    <= ea;
		in_ch.edge_b    <= eb;
		in_ch.max_count <= max_count;
		do begin
			@(posedge clk);
		end while (in_ch.ready !== 1'b1);
		sb.note_input(op, ea, eb, max_count);
	endtask

	// stop offering and wait until every owed result item is back
	task automatic wait_quiet();
		in_ch.valid <= 1'b0;
		while (sb.owed() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write while the block is idle
	task automatic write_prescale(input logic [PRESCALE_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_prescale(value);
	endtask

	// result side: check accepted items, then pick next ready
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
				sb.check_result(out_ch.stamp, out_ch.channel, out_ch.empty_res,
					out_ch.last);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// stimulus
	initial begin
		int                    phase;
		int                    sent;
		int                    kind;
		int                    len;
		int                    edge_pct;
		logic [PRESCALE_W-1:0] next_prescale;
		logic [CNT_W-1:0]      mc;

		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_wdata       <= '0;
		in_ch.valid     <= 1'b0;
		in_ch.opcode    <= OP_TICK;
		in_ch.edge_a    <= 1'b0;
		in_ch.edge_b    <= 1'b0;
		in_ch.max_count <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed items at the reset prescale
		send_item(OP_DRAIN_A, 1'b1, 1'b1, 7'd5);    // empty channel a, edges ignored
		send_item(OP_DRAIN_B, 1'b0, 1'b0, 7'd0);    // empty channel b, zero count
		send_item(OP_IGNORED, 1'b1, 1'b1, 7'd127);  // unused opcode
		send_item(OP_TICK, 1'b1, 1'b1, 7'd0);       // both edges on one tick
		send_item(OP_TICK, 1'b1, 1'b0, 7'd127);
		send_item(OP_TICK, 1'b0, 1'b1, 7'd64);
		send_item(OP_TICK, 1'b0, 1'b0, 7'd0);
		send_item(OP_TICK, 1'b1, 1'b1, 7'd85);
		send_item(OP_DRAIN_A, 1'b0, 1'b1, 7'd0);    // zero count with entries held
		send_item(OP_DRAIN_A, 1'b1, 1'b0, 7'd127);  // count above the result limit
		send_item(OP_DRAIN_B, 1'b0, 1'b0, 7'd1);
		send_item(OP_DRAIN_B, 1'b1, 1'b1, 7'd64);
		send_item(OP_DRAIN_B, 1'b0, 1'b0, 7'd64);
		send_item(OP_IGNORED, 1'b0, 1'b0, 7'd0);
		wait_quiet();

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
					next_prescale  = '0;
				end
				1: begin
					send_idle_pct  = 74;
					recv_stall_pct = 0;
					next_prescale  = '1;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 74;
					next_prescale  = 16'd3;
				end
				default: begin
					send_idle_pct  = 16;
					recv_stall_pct = 16;
					next_prescale  = PRESCALE_W'($urandom_range(1, 65534));
				end
			endcase
			write_prescale(next_prescale);

			// overfill both rings, then drain against a long output hold-off
			if (phase == 0) begin
				repeat (70) send_item(OP_TICK, 1'b1, 1'b1, CNT_W'($urandom));
				hold_left = 300;
				send_item(OP_DRAIN_A, 1'b0, 1'b0, 7'd64);
				send_item(OP_DRAIN_B, 1'b1, 1'b0, 7'd127);
				send_item(OP_DRAIN_A, 1'b0, 1'b1, 7'd10);
				send_item(OP_TICK, 1'b1, 1'b0, 7'd0);
				send_item(OP_DRAIN_A, 1'b0, 1'b0, 7'd3);
				wait_quiet();
			end

			// random runs of ticks mixed with drains and some noise
			sent = 0;
			while (sent < RANDOM_PER_PHASE) begin
				kind = $urandom_range(0, 19);
				if (kind < 11) begin
					len      = $urandom_range(1, 12);
					edge_pct = $urandom_range(10, 90);
					repeat (len) begin
						send_item(OP_TICK, $urandom_range(99) < edge_pct,
							$urandom_range(99) < edge_pct, CNT_W'($urandom));
						sent++;
					end
				end else if (kind < 18) begin
					mc = (kind == 17) ? CNT_W'($urandom_range(64, 127))
						: CNT_W'($urandom_range(0, 9));
					send_item($urandom_range(1) ? OP_DRAIN_B : OP_DRAIN_A,
						1'($urandom), 1'($urandom), mc);
					sent++;
				end else begin
					send_item(OP_IGNORED, 1'($urandom), 1'($urandom), CNT_W'($urandom));
				end
			end
			wait_quiet();
		end

		if (sb.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5ms;
		$display("Regression FAIL");
		$finish;
	end
endmodule

FILE: files.f
design/dtc_pkg.sv
design/dtc_if.sv
design/dtc_front.sv
design/dtc_cmd_queue.sv
design/dtc_back.sv
design/dual_channel_timestamp_capture_fifo_core.sv
tb/tb.sv
